// ----- rtl/core/ps2mpt_pkg.sv -----
`default_nettype none

package ps2mpt_pkg;

    // Width of the screen size registers on the configuration port.
    localparam int CFG_BITS = 13;

    // Register indexes on the configuration port.
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Reset values of the screen size registers.
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

    // Header byte fields.
    localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
    localparam logic [7:0] HDR_SYNC     = 8'h08;
    localparam logic [2:0] HDR_BUTTONS  = 3'h7;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    // Input word kinds carried in s_tuser.
    localparam logic ACT_MOUSE_BYTE = 1'b0;
    localparam logic ACT_RECENTER   = 1'b1;

    // Packet framing phase codes; the unused code behaves like PH_HEADER.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_X_MOVE = 2'd1;
    localparam logic [1:0] PH_Y_MOVE = 2'd2;

    // Per-word status flags, packet_done in the lowest bit.
    typedef struct packed {
        logic byte_discarded;
        logic packet_dropped;
        logic packet_done;
    } flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/ps2_mouse_packet_tracker.sv -----
`default_nettype none

// Channel    Dir  Payload                                         Handshake
// s_*        in   tdata: data_byte; tuser: action                 s_tvalid/s_tready
// m_*        out  tdata: cursor_x, cursor_y, button_bits;         m_tvalid/m_tready
//                 tuser: packet_done, packet_dropped,
//                 byte_discarded
// cfg_*      in   cfg_index, cfg_data (screen width / height)     cfg_valid/cfg_ready
//
// Every input word produces exactly one output word, in the cycle after it is accepted. The phase
// step and one add and clamp per axis are done in the cycle of acceptance and land in the
// output register, so one word per cycle is taken whenever that register is empty or drains
// in the same cycle. A master-side stall holds the output word and stops acceptance until it
// is taken. Reset puts the framer in the header phase, clears the buttons, loads the default
// 640 x 480 screen size and places the cursor at the center of that screen.

module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Input stream.
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                    s_tuser,  // [0] action

    // Output stream.
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // From bit 0 up: cursor_x, cursor_y, button_bits, zero fill.
    output      logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_tdata,
    // [0] packet_done, [1] packet_dropped, [2] byte_discarded
    output      logic [2:0]                    m_tuser,

    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [ps2mpt_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int CW = ps2mpt_pkg::CFG_BITS;
    // Width that holds both a register value and the largest effective size.
    localparam int EW = (CB + 1 > CW) ? CB + 1 : CW;
    localparam int TDATA_BITS = ((2*CB+3+7)/8)*8;
    localparam int PAD_BITS = TDATA_BITS - (2*CB + 3);

    localparam logic [EW-1:0] SIZE_LIM = EW'(1) << CB;

    // Cursor reset position: half of the effective default screen size.
    localparam int LIM_INT = 1 << CB;
    localparam int W0 = int'(ps2mpt_pkg::SCREEN_WIDTH_RESET);
    localparam int H0 = int'(ps2mpt_pkg::SCREEN_HEIGHT_RESET);
    localparam int RESET_X = ((W0 > LIM_INT) ? LIM_INT : W0) / 2;
    localparam int RESET_Y = ((H0 > LIM_INT) ? LIM_INT : H0) / 2;

    // Configuration registers.
    logic [CW-1:0] screen_width_reg;
    logic [CW-1:0] screen_height_reg;

    // Framing and tracking state.
    logic [1:0]    byte_phase_reg, byte_phase_next;
    logic [7:0]    header_byte_reg, header_byte_next;
    logic [7:0]    x_move_byte_reg, x_move_byte_next;
    logic [CB-1:0] pos_x_reg, pos_x_next;
    logic [CB-1:0] pos_y_reg, pos_y_next;
    logic [2:0]    held_buttons_reg, held_buttons_next;

    // Output register.
    logic          out_valid_reg;
    logic [CB-1:0] out_x_reg;
    logic [CB-1:0] out_y_reg;
    logic [2:0]    out_buttons_reg;
    ps2mpt_pkg::flags_t out_flags_reg;
    ps2mpt_pkg::flags_t flags_next;

    // Effective sizes, clamp limits and recenter points.
    logic [EW-1:0] eff_w, eff_h;
    logic [EW-1:0] eff_w_m1, eff_h_m1;
    logic [EW-1:0] half_w, half_h;
    logic [CB-1:0] max_x, max_y;

    // Signed sums of position and movement; two extra bits cover the range.
    logic signed [CB+1:0] dx_ext, dy_ext;
    logic signed [CB+1:0] sum_x, sum_y;
    logic signed [CB+1:0] max_x_ext, max_y_ext;
    logic [CB-1:0] clamp_x, clamp_y;

    logic in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    // A size register of zero behaves as one, and sizes beyond the coordinate
    // range saturate to the full range.
    always_comb
    begin
        if (screen_width_reg == '0)
            eff_w = EW'(1);
        else if (EW'(screen_width_reg) > SIZE_LIM)
            eff_w = SIZE_LIM;
        else
            eff_w = EW'(screen_width_reg);

        if (screen_height_reg == '0)
            eff_h = EW'(1);
        else if (EW'(screen_height_reg) > SIZE_LIM)
            eff_h = SIZE_LIM;
        else
            eff_h = EW'(screen_height_reg);

        eff_w_m1 = eff_w - EW'(1);
        eff_h_m1 = eff_h - EW'(1);
        max_x    = eff_w_m1[CB-1:0];
        max_y    = eff_h_m1[CB-1:0];
        half_w   = eff_w >> 1;
        half_h   = eff_h >> 1;
    end

    // Movement deltas are 9-bit two's complement: sign from the header,
    // low bits from the movement bytes. Screen Y grows downward, so dy is
    // subtracted.
    always_comb
    begin
        dx_ext = (CB+2)'($signed({header_byte_reg[ps2mpt_pkg::HDR_X_SIGN_BIT],
                                  x_move_byte_reg}));
        dy_ext = (CB+2)'($signed({header_byte_reg[ps2mpt_pkg::HDR_Y_SIGN_BIT],
                                  s_tdata}));
        sum_x = $signed({2'b00, pos_x_reg}) + dx_ext;
        sum_y = $signed({2'b00, pos_y_reg}) - dy_ext;
        max_x_ext = $signed({2'b00, max_x});
        max_y_ext = $signed({2'b00, max_y});

        if (sum_x < 0)
            clamp_x = '0;
        else if (sum_x > max_x_ext)
            clamp_x = max_x;
        else
            clamp_x = sum_x[CB-1:0];

        if (sum_y < 0)
            clamp_y = '0;
        else if (sum_y > max_y_ext)
            clamp_y = max_y;
        else
            clamp_y = sum_y[CB-1:0];
    end

    // Packet framer and cursor update for the word at the input.
    always_comb
    begin
        byte_phase_next   = byte_phase_reg;
        header_byte_next  = header_byte_reg;
        x_move_byte_next  = x_move_byte_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        held_buttons_next = held_buttons_reg;
        flags_next        = '0;

        if (s_tuser[0] == ps2mpt_pkg::ACT_RECENTER)
        begin
            pos_x_next = half_w[CB-1:0];
            pos_y_next = half_h[CB-1:0];
        end
        else
        begin
            unique case (byte_phase_reg)
                ps2mpt_pkg::PH_X_MOVE:
                begin
                    x_move_byte_next = s_tdata;
                    byte_phase_next  = ps2mpt_pkg::PH_Y_MOVE;
                end
                ps2mpt_pkg::PH_Y_MOVE:
                begin
                    byte_phase_next = ps2mpt_pkg::PH_HEADER;
                    if ((header_byte_reg & ps2mpt_pkg::HDR_OVERFLOW) != 8'h00)
                    begin
                        flags_next.packet_dropped = 1'b1;
                    end
                    else
                    begin
                        held_buttons_next      = header_byte_reg[2:0] & ps2mpt_pkg::HDR_BUTTONS;
                        pos_x_next             = clamp_x;
                        pos_y_next             = clamp_y;
                        flags_next.packet_done = 1'b1;
                    end
                end
                default:
                begin
                    // Header phase, and the unused phase code: resync on bit 3.
                    if ((s_tdata & ps2mpt_pkg::HDR_SYNC) != 8'h00)
                    begin
                        header_byte_next = s_tdata;
                        byte_phase_next  = ps2mpt_pkg::PH_X_MOVE;
                    end
                    else
                    begin
                        byte_phase_next           = ps2mpt_pkg::PH_HEADER;
                        flags_next.byte_discarded = 1'b1;
                    end
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= ps2mpt_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= ps2mpt_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ps2mpt_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                ps2mpt_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:                       screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    // Tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg   <= ps2mpt_pkg::PH_HEADER;
            header_byte_reg  <= 8'h00;
            x_move_byte_reg  <= 8'h00;
            pos_x_reg        <= CB'(RESET_X);
            pos_y_reg        <= CB'(RESET_Y);
            held_buttons_reg <= 3'b000;
        end
        else if (in_fire)
        begin
            byte_phase_reg   <= byte_phase_next;
            header_byte_reg  <= header_byte_next;
            x_move_byte_reg  <= x_move_byte_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            held_buttons_reg <= held_buttons_next;
        end
    end

    // Output register: valid flag under reset, payload loads on acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_x_reg       <= pos_x_next;
            out_y_reg       <= pos_y_next;
            out_buttons_reg <= held_buttons_next;
            out_flags_reg   <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, out_buttons_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_flags_reg;

endmodule

`default_nettype wire
